// File: rtl/tpm_pkg.sv
`default_nettype none

package tpm_pkg;

  // Which target claims a bus access.
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_RAM  = 3'd1,
    TGT_ROM  = 3'd2,
    TGT_PREG = 3'd3,
    TGT_SPI  = 3'd4
  } target_e;

  localparam int unsigned NUM_PAGES  = 16;
  localparam int unsigned PAGE_W     = 6;
  localparam int unsigned MEM_ADDR_W = 19;

  localparam logic [15:0] ADDR_ROM_BANK = 16'hFF64;
  localparam logic [15:0] ADDR_CTRL     = 16'hFF90;
  localparam logic [15:0] ADDR_TASK     = 16'hFF91;
  localparam logic [15:0] ADDR_PREG     = 16'hFFA0;
  localparam logic [15:0] MASK_PREG     = 16'hFFF0;
  localparam logic [15:0] ADDR_SPI      = 16'hFF6C;
  localparam logic [15:0] MASK_SPI      = 16'hFFFC;
  localparam logic [7:0]  IO_PAGE_HI    = 8'hFF;
  localparam logic [7:0]  CONST_PAGE_HI = 8'hFE;
  localparam logic [11:0] VECTOR_HI     = 12'hFFF;
  localparam logic [2:0]  TOP_SEGMENT   = 3'b111;
  localparam logic [12:0] CONST_OFF_SET = 13'h0100;

  localparam logic [PAGE_W-1:0] PAGE_FIXED = 6'h3F;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        rom_select;
  } item_t;

  typedef struct packed {
    target_e                 target;
    logic [MEM_ADDR_W-1:0]   mem_addr;
    logic                    mem_write;
    logic [7:0]              read_value;
    logic [1:0]              spi_reg;
    logic                    ext_hit;
  } result_t;

  typedef struct packed {
    logic [NUM_PAGES-1:0][PAGE_W-1:0] pages;
    logic                             task_sel;
    logic                             mmu_on;
    logic                             const_ram_on;
    logic [4:0]                       rom_bank_conf;
  } state_t;

  // Register updates requested by one write item.
  typedef struct packed {
    logic              page_we;
    logic [3:0]        page_idx;
    logic [PAGE_W-1:0] page_val;
    logic              ctrl_we;
    logic              mmu_on;
    logic              const_ram_on;
    logic              task_we;
    logic              task_sel;
    logic              rom_we;
    logic [4:0]        rom_bank_conf;
  } update_t;

endpackage

`default_nettype wire

// File: rtl/task_register_page_mapper_unit.sv
`default_nettype none

// Channel   Handshake                   Payload
// -------   -------------------------   ----------------------------------------------
// in        in_valid_i / in_ready_o     cmd_i, addr_i, data_i, rom_select_i
// out       out_valid_o / out_ready_i   target_o, mem_addr_o, mem_write_o,
//                                       read_value_o, spi_reg_o, ext_hit_o
//
// An item is accepted into the input register, where decode runs, and its
// result is then offered from the result register. One item is accepted
// per cycle unless the output stalls; the page and control registers are
// written as an item leaves the input register, so the next item already sees them.
// Reset sets every page register to 0x3F and clears the control bits.
// A stalled output holds its item and the input register behind it.

module task_register_page_mapper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic        rom_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  target_o,
  output logic [18:0] mem_addr_o,
  output logic        mem_write_o,
  output logic [7:0]  read_value_o,
  output logic [1:0]  spi_reg_o,
  output logic        ext_hit_o
);
  import tpm_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  update_t upd;
  state_t  state;
  logic    advance;
  logic    fire;

  // The input stage moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{cmd: cmd_i, addr: addr_i, data: data_i, rom_select: rom_select_i};
    end
  end

  tpm_decode u_decode (
    .item_i  (item_q),
    .state_i (state),
    .res_o   (res_d),
    .upd_o   (upd)
  );

  // Register updates commit only when the item moves into the result register.
  tpm_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .upd_i   (upd),
    .state_o (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign target_o     = res_q.target;
  assign mem_addr_o   = res_q.mem_addr;
  assign mem_write_o  = res_q.mem_write;
  assign read_value_o = res_q.read_value;
  assign spi_reg_o    = res_q.spi_reg;
  assign ext_hit_o    = res_q.ext_hit;

endmodule

`default_nettype wire

// File: rtl/tpm_state.sv
`default_nettype none

module tpm_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tpm_pkg::update_t upd_i,
  output tpm_pkg::state_t  state_o
);
  import tpm_pkg::*;

  state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pages         <= {NUM_PAGES{PAGE_FIXED}};
      state_q.task_sel      <= 1'b0;
      state_q.mmu_on        <= 1'b0;
      state_q.const_ram_on  <= 1'b0;
      state_q.rom_bank_conf <= 5'd0;
    end else if (en_i) begin
      if (upd_i.page_we) begin
        state_q.pages[upd_i.page_idx] <= upd_i.page_val;
      end
      if (upd_i.ctrl_we) begin
        state_q.mmu_on       <= upd_i.mmu_on;
        state_q.const_ram_on <= upd_i.const_ram_on;
      end
      if (upd_i.task_we) begin
        state_q.task_sel <= upd_i.task_sel;
      end
      if (upd_i.rom_we) begin
        state_q.rom_bank_conf <= upd_i.rom_bank_conf;
      end
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

// File: rtl/tpm_decode.sv
`default_nettype none

module tpm_decode (
  input  tpm_pkg::item_t   item_i,
  input  tpm_pkg::state_t  state_i,
  output tpm_pkg::result_t res_o,
  output tpm_pkg::update_t upd_o
);
  import tpm_pkg::*;

  logic              is_spi;
  logic              is_preg;
  logic              crm_fe;
  logic              crm_top;
  logic              window;
  logic [3:0]        page_idx;
  logic [PAGE_W-1:0] page_sel;
  logic [12:0]       offset;
  logic              ram_hit;
  logic [MEM_ADDR_W-1:0] ram_addr;
  logic [MEM_ADDR_W-1:0] rom_addr;

  always_comb begin
    is_spi  = (item_i.addr & MASK_SPI) == ADDR_SPI;
    is_preg = (item_i.addr & MASK_PREG) == ADDR_PREG;
    crm_fe  = state_i.const_ram_on && (item_i.addr[15:8] == CONST_PAGE_HI);
    crm_top = state_i.const_ram_on && (item_i.addr[15:4] == VECTOR_HI);
    window  = state_i.mmu_on && ((item_i.addr[15:8] != IO_PAGE_HI) || crm_top);

    // The page register file has one read port: readback and mapping never
    // need it for the same access.
    page_idx = is_preg ? item_i.addr[3:0] : {state_i.task_sel, item_i.addr[15:13]};
    page_sel = (crm_fe || crm_top) ? PAGE_FIXED : state_i.pages[page_idx];
    offset   = item_i.addr[12:0] | (crm_fe ? CONST_OFF_SET : 13'd0);
    ram_hit  = window && ((page_sel != PAGE_FIXED) || crm_fe || crm_top ||
                          (item_i.addr[15:13] == TOP_SEGMENT));
    ram_addr = {page_sel, offset};

    if (state_i.rom_bank_conf[3]) begin
      rom_addr = {3'd0, state_i.rom_bank_conf[2:1], item_i.addr[13:0]};
    end else begin
      rom_addr = {3'd0, state_i.rom_bank_conf[2:0], item_i.addr[12:0]};
    end

    res_o            = '0;
    res_o.target     = TGT_NONE;
    res_o.read_value = item_i.data;
    upd_o            = '0;
    upd_o.page_idx      = item_i.addr[3:0];
    upd_o.page_val      = item_i.data[5:0];
    upd_o.mmu_on        = item_i.data[6];
    upd_o.const_ram_on  = item_i.data[3];
    upd_o.task_sel      = item_i.data[0];
    upd_o.rom_bank_conf = item_i.data[4:0];

    if (item_i.rom_select) begin
      res_o.target   = TGT_ROM;
      res_o.mem_addr = rom_addr;
    end else if (!item_i.cmd) begin
      if (is_spi) begin
        res_o.target  = TGT_SPI;
        res_o.spi_reg = item_i.addr[1:0];
      end else if (is_preg) begin
        res_o.target     = TGT_PREG;
        res_o.read_value = {2'b00, state_i.pages[page_idx]};
      end else if (ram_hit) begin
        res_o.target   = TGT_RAM;
        res_o.mem_addr = ram_addr;
      end
    end else begin
      upd_o.rom_we = (item_i.addr == ADDR_ROM_BANK) && !state_i.rom_bank_conf[4];
      if (is_spi) begin
        res_o.target  = TGT_SPI;
        res_o.spi_reg = item_i.addr[1:0];
      end
      if (is_preg) begin
        upd_o.page_we = 1'b1;
      end else if (item_i.addr == ADDR_CTRL) begin
        upd_o.ctrl_we = 1'b1;
      end else if (item_i.addr == ADDR_TASK) begin
        upd_o.task_we = 1'b1;
      end else if (ram_hit) begin
        res_o.target    = TGT_RAM;
        res_o.mem_addr  = ram_addr;
        res_o.mem_write = 1'b1;
      end
    end

    res_o.ext_hit = res_o.target == TGT_RAM;
  end

endmodule

`default_nettype wire
